/* rtl/hts_pkg.sv */
// Shared types and constants of the head-turn liveness sequencer.
package hts_pkg;

	// Widths of the fixed item and register fields.
	localparam int TIME_FIELD_W = 32;
	localparam int CFG_DATA_W   = 20;
	localparam int CFG_INDEX_W  = 3;

	// Stage codes.
	localparam logic [1:0] ST_ACQUIRE = 2'd0;
	localparam logic [1:0] ST_TURN    = 2'd1;
	localparam logic [1:0] ST_CENTER  = 2'd2;
	localparam logic [1:0] ST_PASSED  = 2'd3;

	// Action codes.
	localparam logic ACT_FRAME   = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_MATCH_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TURN_DIRECTION  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_FACE_PIXELS = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_AGE_LIMIT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SESSION_LIMIT   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_GAP_LIMIT       = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_TURN_POSE_MIN   = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_POSE_MAX = 3'd7;

	// A stage needs its qualifying frames to span at least this many milliseconds.
	localparam int MIN_SPAN_MS = 200;

	typedef struct packed {
		logic signed [15:0] match_threshold;
		logic               turn_direction;
		logic [15:0]        min_face_pixels;
		logic [15:0]        frame_age_limit;
		logic [19:0]        session_limit;
		logic [15:0]        gap_limit;
		logic [14:0]        turn_pose_min;
		logic [14:0]        center_pose_max;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		match_threshold: 16'sd9830,
		turn_direction:  1'b1,
		min_face_pixels: 16'd120,
		frame_age_limit: 16'd350,
		session_limit:   20'd12000,
		gap_limit:       16'd450,
		turn_pose_min:   15'd160,
		center_pose_max: 15'd100
	};

	typedef struct packed {
		logic                    action;
		logic [TIME_FIELD_W-1:0] now_time;
		logic [TIME_FIELD_W-1:0] capture_time;
		logic signed [15:0]      match_score;
		logic signed [15:0]      head_pose;
		logic [15:0]             face_size;
		logic [3:0]              face_count;
	} item_t;

	typedef struct packed {
		logic       passed_pulse;
		logic [1:0] stage_now;
	} result_t;

endpackage

/* rtl/hts_if.sv */
// Request and result channel interfaces of the head-turn liveness sequencer.
interface hts_item_if;
	logic                             valid;
	logic                             ready;
	logic                             action;
	logic [hts_pkg::TIME_FIELD_W-1:0] now_time;
	logic [hts_pkg::TIME_FIELD_W-1:0] capture_time;
	logic signed [15:0]               match_score;
	logic signed [15:0]               head_pose;
	logic [15:0]                      face_size;
	logic [3:0]                       face_count;

	modport source (output valid, action, now_time, capture_time, match_score,
		head_pose, face_size, face_count, input ready);
	modport sink (input valid, action, now_time, capture_time, match_score,
		head_pose, face_size, face_count, output ready);
endinterface

interface hts_result_if;
	logic       valid;
	logic       ready;
	logic       passed_pulse;
	logic [1:0] stage_now;

	modport source (output valid, passed_pulse, stage_now, input ready);
	modport sink (input valid, passed_pulse, stage_now, output ready);
endinterface

/* rtl/hts_eval.sv */
// Next-state and result logic for one request of the liveness sequencer.
module hts_eval #(
	parameter int HOLD_FRAMES = 3,
	parameter int TIME_W      = 32,
	parameter int HIT_W       = 2
) (
	input  hts_pkg::cfg_t      cfg,
	input  hts_pkg::item_t     it,
	input  logic [1:0]         stage,
	input  logic [HIT_W-1:0]   hit_count,
	input  logic [TIME_W-1:0]  first_hit_time,
	input  logic [TIME_W-1:0]  last_capture,
	input  logic               have_last,
	input  logic [TIME_W-1:0]  session_start,
	output logic [1:0]         stage_nxt,
	output logic [HIT_W-1:0]   hit_count_nxt,
	output logic [TIME_W-1:0]  first_hit_time_nxt,
	output logic [TIME_W-1:0]  last_capture_nxt,
	output logic               have_last_nxt,
	output logic [TIME_W-1:0]  session_start_nxt,
	output hts_pkg::result_t   res
);

	// Limits are compared at a width that holds both a time difference and the widest limit.
	localparam int CMP_W = (TIME_W > 20) ? TIME_W : 20;
	localparam logic [HIT_W-1:0] HOLD = HIT_W'(HOLD_FRAMES);

	logic [TIME_W-1:0]  now_t;
	logic [TIME_W-1:0]  cap_t;
	logic [CMP_W-1:0]   age_x;
	logic [CMP_W-1:0]   sess_age_x;
	logic [CMP_W-1:0]   gap_x;
	logic               frame_ok;
	logic               stale;
	logic               gap_hit;
	logic [1:0]         stage_g;
	logic [HIT_W-1:0]   hit_g;
	logic [TIME_W-1:0]  first_g;
	logic signed [16:0] pose_x;
	logic signed [16:0] pose_neg;
	logic signed [16:0] pose_abs;
	logic signed [16:0] turn_min_x;
	logic signed [16:0] center_max_x;
	logic               qualifies;
	logic [TIME_W-1:0]  first_q;
	logic [HIT_W-1:0]   hit_inc;
	logic               span_ok;
	logic               stage_done;

	assign now_t = it.now_time[TIME_W-1:0];
	assign cap_t = it.capture_time[TIME_W-1:0];

	assign age_x      = CMP_W'(now_t - cap_t);
	assign sess_age_x = CMP_W'(now_t - session_start);
	assign gap_x      = CMP_W'(cap_t - last_capture);

	assign frame_ok = (it.face_count == 4'd1)
		&& (it.match_score >= cfg.match_threshold)
		&& (it.face_size >= cfg.min_face_pixels)
		&& (now_t >= cap_t)
		&& (age_x <= CMP_W'(cfg.frame_age_limit))
		&& (now_t >= session_start)
		&& (sess_age_x <= CMP_W'(cfg.session_limit));

	assign stale   = have_last && (cap_t <= last_capture);
	assign gap_hit = have_last && (gap_x > CMP_W'(cfg.gap_limit));

	// A long capture gap restarts progress, but the frame is still scored afterwards.
	assign stage_g = gap_hit ? hts_pkg::ST_ACQUIRE : stage;
	assign hit_g   = gap_hit ? '0 : hit_count;
	assign first_g = gap_hit ? '0 : first_hit_time;

	assign pose_x       = 17'(it.head_pose);
	assign pose_neg     = -pose_x;
	assign pose_abs     = pose_x[16] ? pose_neg : pose_x;
	assign turn_min_x   = $signed({2'b00, cfg.turn_pose_min});
	assign center_max_x = $signed({2'b00, cfg.center_pose_max});

	always_comb begin
		if (stage_g == hts_pkg::ST_TURN) begin
			qualifies = cfg.turn_direction ? (pose_x > turn_min_x) : (pose_neg > turn_min_x);
		end else begin
			qualifies = pose_abs < center_max_x;
		end
	end

	assign first_q    = (hit_g == '0) ? cap_t : first_g;
	assign hit_inc    = (hit_g < HOLD) ? hit_g + HIT_W'(1) : hit_g;
	assign span_ok    = (cap_t >= first_q)
		&& ((cap_t - first_q) >= TIME_W'(hts_pkg::MIN_SPAN_MS));
	assign stage_done = (hit_inc >= HOLD) && span_ok;

	always_comb begin
		stage_nxt          = stage;
		hit_count_nxt      = hit_count;
		first_hit_time_nxt = first_hit_time;
		last_capture_nxt   = last_capture;
		have_last_nxt      = have_last;
		session_start_nxt  = session_start;
		res.passed_pulse   = 1'b0;
		priority if (it.action == hts_pkg::ACT_RESTART) begin
			stage_nxt          = hts_pkg::ST_ACQUIRE;
			hit_count_nxt      = '0;
			first_hit_time_nxt = '0;
			last_capture_nxt   = '0;
			have_last_nxt      = 1'b0;
			session_start_nxt  = now_t;
		end else if (stage == hts_pkg::ST_PASSED) begin
			// Frames are ignored until the next restart.
		end else if (!frame_ok || stale) begin
			stage_nxt          = hts_pkg::ST_ACQUIRE;
			hit_count_nxt      = '0;
			first_hit_time_nxt = '0;
			last_capture_nxt   = '0;
			have_last_nxt      = 1'b0;
		end else begin
			last_capture_nxt = cap_t;
			have_last_nxt    = 1'b1;
			stage_nxt        = stage_g;
			if (!qualifies) begin
				hit_count_nxt      = '0;
				first_hit_time_nxt = '0;
			end else begin
				first_hit_time_nxt = first_q;
				hit_count_nxt      = hit_inc;
				if (stage_done) begin
					hit_count_nxt = '0;
					unique case (stage_g)
						hts_pkg::ST_ACQUIRE: stage_nxt = hts_pkg::ST_TURN;
						hts_pkg::ST_TURN:    stage_nxt = hts_pkg::ST_CENTER;
						default: begin
							stage_nxt        = hts_pkg::ST_PASSED;
							res.passed_pulse = 1'b1;
						end
					endcase
				end
			end
		end
		res.stage_now = stage_nxt;
	end

endmodule

/* rtl/head_turn_liveness_sequencer.sv */
// Head-turn liveness sequencer: request register, sequencing state and result register.
//
// Usage: each request on "item" is either a restart (action = 1, session starts at
// now_time) or one face-detector frame report. Every request yields exactly one
// result on "result": the stage after the request and a flag passed_pulse that is
// set only in the result of the frame that completes the center stage.
// Both channels use valid/ready; a request moves when both are high.
// An accepted request waits in the request register and its result in the result
// register; one request per cycle unless the result is stalled. The request
// register feeds the compare and update logic, which writes the sequencing state
// and the result register in the same cycle; the next request sees the new state.
// When the receiver holds ready low, the result register holds its value, the
// request register fills, and item.ready drops until the result is taken.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata and
// should only change while no request is in flight.
// Reset clears the stage to acquire, the progress and session state to zero,
// the channels to empty, and loads the documented register defaults.
module head_turn_liveness_sequencer #(
	parameter int HOLD_FRAMES = 3,
	parameter int TIME_BITS   = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [hts_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [hts_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	hts_item_if.sink                            item,
	hts_result_if.source                        result
);

	localparam int TIME_W = (TIME_BITS < hts_pkg::TIME_FIELD_W) ? TIME_BITS
		: hts_pkg::TIME_FIELD_W;
	localparam int HIT_W  = $clog2(HOLD_FRAMES + 1);

	hts_pkg::cfg_t    cfg_q;
	hts_pkg::item_t   item_s1;
	logic             valid_s1;
	hts_pkg::result_t res_q;
	logic             res_valid_q;

	logic [1:0]        stage_q;
	logic [HIT_W-1:0]  hit_count_q;
	logic [TIME_W-1:0] first_hit_time_q;
	logic [TIME_W-1:0] last_capture_q;
	logic              have_last_q;
	logic [TIME_W-1:0] session_start_q;

	logic [1:0]        stage_nxt;
	logic [HIT_W-1:0]  hit_count_nxt;
	logic [TIME_W-1:0] first_hit_time_nxt;
	logic [TIME_W-1:0] last_capture_nxt;
	logic              have_last_nxt;
	logic [TIME_W-1:0] session_start_nxt;
	hts_pkg::result_t  res_nxt;

	logic advance;
	logic take_in;

	assign advance     = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready  = !valid_s1 || advance;
	assign take_in     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= hts_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				hts_pkg::REG_MATCH_THRESHOLD: cfg_q.match_threshold <= cfg_wdata[15:0];
				hts_pkg::REG_TURN_DIRECTION:  cfg_q.turn_direction  <= cfg_wdata[0];
				hts_pkg::REG_MIN_FACE_PIXELS: cfg_q.min_face_pixels <= cfg_wdata[15:0];
				hts_pkg::REG_FRAME_AGE_LIMIT: cfg_q.frame_age_limit <= cfg_wdata[15:0];
				hts_pkg::REG_SESSION_LIMIT:   cfg_q.session_limit   <= cfg_wdata[19:0];
				hts_pkg::REG_GAP_LIMIT:       cfg_q.gap_limit       <= cfg_wdata[15:0];
				hts_pkg::REG_TURN_POSE_MIN:   cfg_q.turn_pose_min   <= cfg_wdata[14:0];
				hts_pkg::REG_CENTER_POSE_MAX: cfg_q.center_pose_max <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.action       <= item.action;
			item_s1.now_time     <= item.now_time;
			item_s1.capture_time <= item.capture_time;
			item_s1.match_score  <= item.match_score;
			item_s1.head_pose    <= item.head_pose;
			item_s1.face_size    <= item.face_size;
			item_s1.face_count   <= item.face_count;
		end
	end

	hts_eval #(
		.HOLD_FRAMES(HOLD_FRAMES),
		.TIME_W     (TIME_W),
		.HIT_W      (HIT_W)
	) u_eval (
		.cfg               (cfg_q),
		.it                (item_s1),
		.stage             (stage_q),
		.hit_count         (hit_count_q),
		.first_hit_time    (first_hit_time_q),
		.last_capture      (last_capture_q),
		.have_last         (have_last_q),
		.session_start     (session_start_q),
		.stage_nxt         (stage_nxt),
		.hit_count_nxt     (hit_count_nxt),
		.first_hit_time_nxt(first_hit_time_nxt),
		.last_capture_nxt  (last_capture_nxt),
		.have_last_nxt     (have_last_nxt),
		.session_start_nxt (session_start_nxt),
		.res               (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q          <= hts_pkg::ST_ACQUIRE;
			hit_count_q      <= '0;
			first_hit_time_q <= '0;
			last_capture_q   <= '0;
			have_last_q      <= 1'b0;
			session_start_q  <= '0;
		end else if (advance) begin
			stage_q          <= stage_nxt;
			hit_count_q      <= hit_count_nxt;
			first_hit_time_q <= first_hit_time_nxt;
			last_capture_q   <= last_capture_nxt;
			have_last_q      <= have_last_nxt;
			session_start_q  <= session_start_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.passed_pulse = res_q.passed_pulse;
	assign result.stage_now    = res_q.stage_now;

endmodule
